// ===== design/bdq_pkg.sv =====
package bdq_pkg;

  // field widths fixed by the record format
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned GRADE_W = 10;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;

  // command codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND       = 3'd4;
  localparam logic [FUNC_W-1:0] FN_POSITION   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FRONT      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_BACK       = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [KEY_W-1:0]  key_in;
    logic [GRADE_W-1:0]       grade_one_in;
    logic [GRADE_W-1:0]       grade_two_in;
    logic [GRADE_W-1:0]       grade_three_in;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [KEY_W-1:0]  key_out;
    logic [GRADE_W-1:0]       grade_one_out;
    logic [GRADE_W-1:0]       grade_two_out;
    logic [GRADE_W-1:0]       grade_three_out;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         entry_count;
  } res_t;

  // one stored record
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [GRADE_W-1:0]       g1;
    logic [GRADE_W-1:0]       g2;
    logic [GRADE_W-1:0]       g3;
  } rec_t;

  // per-cycle action of every cell in the row
  typedef enum logic [1:0] {
    CO_HOLD,    // keep record
    CO_SHR,     // take left neighbor (push front)
    CO_SHL,     // take right neighbor (pop front)
    CO_APPEND   // cell at the back slot takes the new record
  } cell_op_e;

  // search token walking down the row
  typedef struct packed {
    logic                     valid;
    logic                     back_mode;  // look for the last held cell, not a key
    logic signed [KEY_W-1:0]  key;
    logic                     hit;
    rec_t                     rec;
    logic [POS_W-1:0]         pos;
  } probe_t;

endpackage

// ===== design/bdq_cell.sv =====
module bdq_cell import bdq_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_op_e      op_i,
  input  rec_t          left_i,
  input  rec_t          right_i,
  input  rec_t          new_i,
  input  logic [CW-1:0] count_i,
  input  probe_t        probe_i,
  output rec_t          rec_o,
  output probe_t        probe_o
);

  localparam logic [CW-1:0]    MY_IDX = CW'(IDX);
  localparam logic [CW-1:0]    NEXT   = CW'(IDX + 1);
  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX + 1);

  rec_t   rec_q, rec_d;
  probe_t probe_q, probe_d;
  logic   held, match;

  always_comb begin
    rec_d = rec_q;
    unique case (op_i)
      CO_HOLD:   rec_d = rec_q;
      CO_SHR:    rec_d = left_i;
      CO_SHL:    rec_d = right_i;
      CO_APPEND: if (count_i == MY_IDX) rec_d = new_i;
      default:   rec_d = rec_q;
    endcase
  end

  // compare against the passing token
  always_comb begin
    held    = count_i > MY_IDX;
    match   = probe_i.back_mode ? (count_i == NEXT) : (held && (rec_q.key == probe_i.key));
    probe_d = probe_i;
    if (probe_i.valid && !probe_i.hit && match) begin
      probe_d.hit = 1'b1;
      probe_d.rec = rec_q;
      probe_d.pos = MY_POS;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign rec_o   = rec_q;
  assign probe_o = probe_q;

endmodule

// ===== design/bounded_deque_with_key_search.sv =====
// Bounded double-ended queue of records (signed key plus three grades) with key
// lookup. A command is taken when start is high and busy is low; each
// command yields exactly one result, shown on res_o for one cycle while done_o
// is high, and the receiver cannot stall it. Records sit in a row of DEPTH
// cells, front in cell 0. Pushes, pops and the front read need no search:
// the result appears the cycle after the transfer and a new command
// can be taken right away. Find, position and back reads send a search token
// down the cell row, one cell per cycle, and hold busy high until the token
// leaves the last cell; the result is registered from the token. A find
// with a negative key, and any lookup on an empty queue, skips the search.
module bounded_deque_with_key_search import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  cmd_t  cmd_i,
  output logic  busy,
  output logic  done_o,
  output res_t  res_o
);

  // count needs to reach DEPTH itself
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]     count_q, count_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;
  logic [FUNC_W-1:0] func_q;
  logic              accept;
  cell_op_e          cell_op;
  rec_t              new_rec;
  probe_t            launch;
  probe_t            probe_w [DEPTH+1];
  rec_t              rec_w   [DEPTH];
  probe_t            probe_end;

  assign accept  = start && !busy_q;
  assign new_rec = '{key: cmd_i.key_in, g1: cmd_i.grade_one_in,
                     g2: cmd_i.grade_two_in, g3: cmd_i.grade_three_in};

  // row of cells, each handing its record and the search token to its neighbor
  assign probe_w[0] = launch;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec, right_rec;
    if (i == 0) begin : g_first
      assign left_rec = new_rec;
    end else begin : g_mid_l
      assign left_rec = rec_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_rec = new_rec;  // slot becomes unused after pop front
    end else begin : g_mid_r
      assign right_rec = rec_w[i+1];
    end
    bdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .left_i  (left_rec),
      .right_i (right_rec),
      .new_i   (new_rec),
      .count_i (count_q),
      .probe_i (probe_w[i]),
      .rec_o   (rec_w[i]),
      .probe_o (probe_w[i+1])
    );
  end

  assign probe_end = probe_w[DEPTH];

  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    res_d   = '0;
    cell_op = CO_HOLD;
    launch  = '0;
    launch.key = cmd_i.key_in;

    if (accept) begin
      done_d = 1'b1;
      res_d.status = ST_OK;
      unique case (cmd_i.func)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (count_q == FULL_CNT) begin
            res_d.status = ST_FULL;
          end else begin
            cell_op = (cmd_i.func == FN_PUSH_FRONT) ? CO_SHR : CO_APPEND;
            count_d = count_q + CW'(1);
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (count_q == '0) begin
            res_d.status = ST_MISS;
          end else begin
            if (cmd_i.func == FN_POP_FRONT) cell_op = CO_SHL;
            count_d = count_q - CW'(1);
          end
        end
        FN_FRONT: begin
          if (count_q == '0) begin
            res_d.status = ST_MISS;
          end else begin
            res_d.key_out         = rec_w[0].key;
            res_d.grade_one_out   = rec_w[0].g1;
            res_d.grade_two_out   = rec_w[0].g2;
            res_d.grade_three_out = rec_w[0].g3;
          end
        end
        FN_FIND, FN_POSITION, FN_BACK: begin
          // negative key on find never searches
          if (count_q == '0 || (cmd_i.func == FN_FIND && cmd_i.key_in[KEY_W-1])) begin
            res_d.status = ST_MISS;
          end else begin
            done_d           = 1'b0;
            busy_d           = 1'b1;
            launch.valid     = 1'b1;
            launch.back_mode = (cmd_i.func == FN_BACK);
          end
        end
        default: res_d.status = ST_MISS;
      endcase
      res_d.entry_count = POS_W'(count_d);
    end else if (probe_end.valid) begin
      // token left the last cell: build the lookup result
      done_d = 1'b1;
      busy_d = 1'b0;
      res_d.entry_count = POS_W'(count_q);
      if (!probe_end.hit) begin
        res_d.status = ST_MISS;
      end else begin
        res_d.status = ST_OK;
        if (func_q != FN_POSITION) begin
          res_d.key_out         = probe_end.rec.key;
          res_d.grade_one_out   = probe_end.rec.g1;
          res_d.grade_two_out   = probe_end.rec.g2;
          res_d.grade_three_out = probe_end.rec.g3;
        end
        if (func_q != FN_BACK) res_d.position = probe_end.pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) func_q <= cmd_i.func;
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  // count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above capacity");

  // a token only reaches the end of the row during a lookup
  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe_end.valid |-> busy_q)
    else $error("search token without pending lookup");

  // a push that is not refused grows the queue by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.func == FN_PUSH_FRONT || cmd_i.func == FN_PUSH_BACK) &&
     count_q != FULL_CNT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the queue");

  // the queue does not change while a lookup is under way
  a_busy_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && $past(busy_q)) |-> $stable(count_q))
    else $error("entry count moved during lookup");
`endif

endmodule
